/* src/gfi_pkg.sv */
// Shared types and constants for the GF(2^128) inverter.
`timescale 1ns / 1ps

package gfi_pkg;

  localparam int FIELD_BITS = 128;
  localparam int HALF_BITS  = FIELD_BITS / 2;
  localparam int WORK_BITS  = FIELD_BITS + 1;

  // Terms of the field polynomial below its leading term: x^7 + x^2 + x + 1.
  localparam logic [FIELD_BITS-1:0] POLY_LOW = FIELD_BITS'(8'h87);

  typedef struct packed {
    logic [HALF_BITS-1:0] value_high;
    logic [HALF_BITS-1:0] value_low;
  } in_item_t;

  typedef struct packed {
    logic [HALF_BITS-1:0] inverse_high;
    logic [HALF_BITS-1:0] inverse_low;
    logic                 zero_error;
  } out_item_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;
    logic shift_u;
    logic shift_v;
    logic combine;
    logic emit;
  } gfi_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic trivial;
    logic u_zero;
    logic u_odd;
    logic v_odd;
  } gfi_status_t;

endpackage

/* src/gfi_datapath.sv */
// Working registers, companion accumulators and result register of the inverter.
`timescale 1ns / 1ps

module gfi_datapath import gfi_pkg::*; (
  input  logic        clk,
  input  in_item_t    in_data,
  input  gfi_cmd_t    cmd,
  output gfi_status_t status,
  output out_item_t   out_data
);

  logic [WORK_BITS-1:0]  u;
  logic [WORK_BITS-1:0]  v;
  logic [FIELD_BITS-1:0] b;
  logic [FIELD_BITS-1:0] d;
  logic                  trivial;
  logic                  zero_flag;

  logic [FIELD_BITS-1:0] in_value;
  logic                  in_zero;
  logic                  in_one;
  logic                  u_ge_v;

  // Halve a companion modulo the field polynomial: fold the polynomial in when odd.
  function automatic logic [FIELD_BITS-1:0] halve_mod(input logic [FIELD_BITS-1:0] c);
    logic [FIELD_BITS-1:0] folded;
    folded = c[0] ? (c ^ POLY_LOW) : c;
    return {c[0], folded[FIELD_BITS-1:1]};
  endfunction

  assign in_value = {in_data.value_high, in_data.value_low};
  assign in_zero  = (in_value == '0);
  assign in_one   = (in_value == FIELD_BITS'(1));
  assign u_ge_v   = (u >= v);

  assign status.trivial = trivial;
  assign status.u_zero  = (u == '0);
  assign status.u_odd   = u[0];
  assign status.v_odd   = v[0];

  // Load, shift or combine the working pair.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      u         <= {1'b1, POLY_LOW};
      v         <= {1'b0, in_value};
      b         <= '0;
      d         <= in_zero ? '0 : FIELD_BITS'(1);
      trivial   <= in_zero | in_one;
      zero_flag <= in_zero;
    end else begin
      if (cmd.shift_u) begin
        u <= u >> 1;
        b <= halve_mod(b);
      end
      if (cmd.shift_v) begin
        v <= v >> 1;
        d <= halve_mod(d);
      end
      if (cmd.combine) begin
        if (u_ge_v) begin
          u <= u ^ v;
          b <= b ^ d;
        end else begin
          v <= v ^ u;
          d <= d ^ b;
        end
      end
    end
  end

  // Capture the result for transfer.
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data.inverse_high <= d[FIELD_BITS-1:HALF_BITS];
      out_data.inverse_low  <= d[HALF_BITS-1:0];
      out_data.zero_error   <= zero_flag;
    end
  end

endmodule

/* src/gfi_ctrl.sv */
// Sequencer for the binary Euclidean inversion loop and the output handshake.
`timescale 1ns / 1ps

module gfi_ctrl import gfi_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  output logic        out_valid,
  input  logic        out_stall,
  input  gfi_status_t status,
  output gfi_cmd_t    cmd
);

  localparam logic [1:0] S_IDLE    = 2'd0;
  localparam logic [1:0] S_HALVE_U = 2'd1;
  localparam logic [1:0] S_HALVE_V = 2'd2;
  localparam logic [1:0] S_FINISH  = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       slot_free;

  assign in_stall  = rst || (state != S_IDLE);
  assign slot_free = !out_valid || !out_stall;

  // Decide the step for this cycle.
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_HALVE_U;
        end
      end
      S_HALVE_U: begin
        if (status.trivial || status.u_zero) begin
          state_next = S_FINISH;
        end else if (!status.u_odd) begin
          cmd.shift_u = 1'b1;
        end else if (!status.v_odd) begin
          cmd.shift_v = 1'b1;
          state_next  = S_HALVE_V;
        end else begin
          cmd.combine = 1'b1;
        end
      end
      S_HALVE_V: begin
        if (!status.v_odd) begin
          cmd.shift_v = 1'b1;
        end else begin
          cmd.combine = 1'b1;
          state_next  = S_HALVE_U;
        end
      end
      S_FINISH: begin
        if (slot_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Advance the state and track the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

/* src/gf2_128_inverter.sv */
// Top level of the GF(2^128) inverter: controller plus datapath.
// Path: a zero or one input goes from the load through the halve-U and finish states
// to the result register; otherwise the loop takes one halving or XOR step at a time
// until u reaches zero, and the finish state waits while the output slot is held.
// Flow: one item at a time; input stalls from the load until the result is emitted.
// Reset: rst is synchronous and clears the sequencer and output valid only.
`timescale 1ns / 1ps

module gf2_128_inverter import gfi_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  gfi_cmd_t    cmd;
  gfi_status_t status;

  gfi_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  gfi_datapath u_datapath (
    .clk      (clk),
    .in_data  (in_data),
    .cmd      (cmd),
    .status   (status),
    .out_data (out_data)
  );

endmodule
